// File: hdl/dq_pkg.sv
// dq_pkg: shared operation codes, status codes and the cell command struct
// for the double-ended queue. No dependencies.
package dq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int PORT_WORD_W = 32;
	localparam int PORT_COUNT_W = 5;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT = 3'd2;
	localparam logic [2:0] MODE_POP_BACK = 3'd3;
	localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [2:0] MODE_PEEK_BACK = 3'd5;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_cmd_t;

endpackage

// File: hdl/dq_cell.sv
// dq_cell: one slot of the shifting deque row, holding a word and an
// occupied flag. Depends on dq_pkg for cell_cmd_t.
module dq_cell
	import dq_pkg::*;
#(
	parameter int STORE_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_cmd_t          cmd,
	input  logic [STORE_W-1:0] push_data,
	input  logic [STORE_W-1:0] left_data,
	input  logic               left_occ,
	input  logic [STORE_W-1:0] right_data,
	input  logic               right_occ,
	output logic [STORE_W-1:0] data,
	output logic               occ,
	output logic [STORE_W-1:0] back_word
);

	logic [STORE_W-1:0] data_q;
	logic               occ_q;
	logic               tail_slot;
	logic               is_last;

	assign tail_slot = !occ_q && left_occ;
	assign is_last = occ_q && !right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				occ_q <= left_occ;
			end else if (cmd.push_back) begin
				if (tail_slot) begin
					occ_q <= 1'b1;
				end
			end else if (cmd.pop_front) begin
				occ_q <= right_occ;
			end else if (cmd.pop_back) begin
				if (is_last) begin
					occ_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.push_back) begin
			if (tail_slot) begin
				data_q <= push_data;
			end
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
	assign occ = occ_q;
	assign back_word = is_last ? data_q : '0;

endmodule

// File: hdl/double_ended_queue.sv
// double_ended_queue: bounded deque built as a row of shifting cells.
// A result is written into the output register by the transfer.
// Throughput: one operation per cycle while out_ready holds; the output register frees in the cycle it is taken.
// The front word always sits in the first cell; the back word is picked by an and-or over the row.
// Reset clears the occupied flags, the count and the output valid; stored words are not cleared.
// Depends on dq_pkg and dq_cell.
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              mode,
	input  logic [PORT_WORD_W-1:0]  data_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PORT_WORD_W-1:0]  data_out,
	output logic [1:0]              status,
	output logic [PORT_COUNT_W-1:0] count
);

	localparam int STORE_W = (WORD_WIDTH < PORT_WORD_W) ? WORD_WIDTH : PORT_WORD_W;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [STORE_W-1:0] cell_data [DEPTH];
	logic [STORE_W-1:0] cell_back [DEPTH];
	logic [DEPTH-1:0]   cell_occ;
	logic [STORE_W-1:0] push_word;
	logic [STORE_W-1:0] back_word;
	logic [STORE_W-1:0] res_word;
	logic [STORE_W+PORT_WORD_W-1:0] res_ext;
	logic [CNT_W+PORT_COUNT_W-1:0]  cnt_ext;
	logic [1:0]         res_status;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_next;
	logic               xfer;
	logic               empty;
	logic               full;
	cell_cmd_t          cmd;

	logic                    out_valid_q;
	logic [PORT_WORD_W-1:0]  data_out_q;
	logic [1:0]              status_q;
	logic [PORT_COUNT_W-1:0] count_q;

	assign push_word = data_in[STORE_W-1:0];
	assign in_ready = !out_valid_q || out_ready;
	assign xfer = in_valid && in_ready;
	assign empty = !cell_occ[0];
	assign full = cell_occ[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [STORE_W-1:0] l_data;
		logic               l_occ;
		logic [STORE_W-1:0] r_data;
		logic               r_occ;
		if (i == 0) begin : g_first
			assign l_data = push_word;
			assign l_occ = 1'b1;
		end else begin : g_mid_l
			assign l_data = cell_data[i-1];
			assign l_occ = cell_occ[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign r_data = '0;
			assign r_occ = 1'b0;
		end else begin : g_mid_r
			assign r_data = cell_data[i+1];
			assign r_occ = cell_occ[i+1];
		end
		dq_cell #(
			.STORE_W(STORE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.push_data (push_word),
			.left_data (l_data),
			.left_occ  (l_occ),
			.right_data(r_data),
			.right_occ (r_occ),
			.data      (cell_data[i]),
			.occ       (cell_occ[i]),
			.back_word (cell_back[i])
		);
	end

	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | cell_back[i];
		end
	end

	always_comb begin
		cmd = '0;
		res_word = '0;
		res_status = STATUS_OK;
		cnt_next = cnt_q;
		unique case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					res_status = STATUS_FULL;
				end else begin
					cmd.push_front = xfer && (mode == MODE_PUSH_FRONT);
					cmd.push_back = xfer && (mode == MODE_PUSH_BACK);
					cnt_next = cnt_q + 1'b1;
				end
			end
			MODE_POP_FRONT, MODE_PEEK_FRONT: begin
				if (empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					res_word = cell_data[0];
					if (mode == MODE_POP_FRONT) begin
						cmd.pop_front = xfer;
						cnt_next = cnt_q - 1'b1;
					end
				end
			end
			MODE_POP_BACK, MODE_PEEK_BACK: begin
				if (empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					res_word = back_word;
					if (mode == MODE_POP_BACK) begin
						cmd.pop_back = xfer;
						cnt_next = cnt_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res_ext = {{PORT_WORD_W{1'b0}}, res_word};
	assign cnt_ext = {{PORT_COUNT_W{1'b0}}, cnt_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				cnt_q <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			data_out_q <= res_ext[PORT_WORD_W-1:0];
			status_q <= res_status;
			count_q <= cnt_ext[PORT_COUNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign data_out = data_out_q;
	assign status = status_q;
	assign count = count_q;

`ifndef ASSERT_OFF
	a_front_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cell_occ[0] == (cnt_q != '0))
		else $error("first cell occupancy disagrees with count");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cell_occ[DEPTH-1] == (cnt_q == FULL_CNT))
		else $error("last cell occupancy disagrees with count");

	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_occ + 1'b1) & cell_occ) == '0)
		else $error("occupied cells are not a contiguous run from the front");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && full && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK)
		|=> status_q == STATUS_FULL && $stable(cnt_q))
		else $error("push on full deque not dropped");
`endif

endmodule

// File: dv/double_ended_queue_test.sv
// double_ended_queue_test: self-checking bench for the bounded deque, a directed table
// followed by weighted random operations, each result checked against the table's fixed want or a shadow deque.
// Depends on dq_pkg and the double_ended_queue rtl.
module double_ended_queue_test;
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH_DEF);
	localparam int RANDOM_OPS = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [PORT_WORD_W-1:0]  word;
		logic [1:0]              code;
		logic [PORT_COUNT_W-1:0] length;
	} dq_result_t;

	typedef struct {
		logic [2:0]             op;
		logic [PORT_WORD_W-1:0] word;
		bit                     fixed;
		dq_result_t             want;
	} stim_row_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;
	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_style_e;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [2:0]              mode;
	logic [PORT_WORD_W-1:0]  data_in;
	logic                    out_valid;
	logic                    out_ready;
	logic [PORT_WORD_W-1:0]  data_out;
	logic [1:0]              status;
	logic [PORT_COUNT_W-1:0] count;

	logic                    row_fixed;
	dq_result_t              row_want;

	logic [PORT_WORD_W-1:0]  shadow_words [DEPTH_DEF];
	logic [IDX_W-1:0]        shadow_front = '0;
	logic [IDX_W-1:0]        shadow_back = '0;
	logic [PORT_COUNT_W-1:0] shadow_len = '0;

	dq_result_t              pending_replies [$];
	dq_result_t              got_reply;
	dq_result_t              want_reply;
	stim_row_t               directed_rows [$];
	int                      fail_count = 0;
	int                      cycle_count = 0;
	int                      burst_left;
	rx_style_e               rx_style;
	int                      rx_left;
	int                      rx_tick;

	double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.status    (status),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH_DEF - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH_DEF - 1) : i - 1'b1;
	endfunction

	// applies one operation to the shadow deque and returns its result
	function automatic dq_result_t step_deque(input logic [2:0] op,
			input logic [PORT_WORD_W-1:0] word);
		dq_result_t res;
		logic [IDX_W-1:0] last;
		res = '0;
		case (op)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (shadow_len >= DEPTH_DEF) begin
					res.code = STATUS_FULL;
				end else if (op == MODE_PUSH_FRONT) begin
					shadow_front = prev_slot(shadow_front);
					shadow_words[shadow_front] = word;
					shadow_len++;
				end else begin
					shadow_words[shadow_back] = word;
					shadow_back = next_slot(shadow_back);
					shadow_len++;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
				if (shadow_len == 0) begin
					res.code = STATUS_EMPTY;
				end else if (op == MODE_POP_FRONT || op == MODE_PEEK_FRONT) begin
					res.word = shadow_words[shadow_front];
					if (op == MODE_POP_FRONT) begin
						shadow_front = next_slot(shadow_front);
						shadow_len--;
					end
				end else begin
					last = prev_slot(shadow_back);
					res.word = shadow_words[last];
					if (op == MODE_POP_BACK) begin
						shadow_back = last;
						shadow_len--;
					end
				end
			end
			default: ;
		endcase
		res.length = shadow_len;
		return res;
	endfunction

	function automatic logic [2:0] pick_mode(input op_mix_e mix);
		int roll;
		int push_cut;
		int pop_cut;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				push_cut = 63;
				pop_cut = 83;
			end
			MIX_DRAIN: begin
				push_cut = 23;
				pop_cut = 83;
			end
			default: begin
				push_cut = 41;
				pop_cut = 79;
			end
		endcase
		if (roll < 3)
			return $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
		if (roll < push_cut)
			return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
		if (roll < pop_cut)
			return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
		return $urandom_range(0, 1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT;
	endfunction

	function automatic logic [PORT_WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return PORT_WORD_W'($urandom);
	endfunction

	// called at a rising edge; returns at the rising edge of the transfer
	task automatic send_op(input logic [2:0] op, input logic [PORT_WORD_W-1:0] word,
			input bit fixed, input dq_result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= op;
		data_in <= word;
		row_fixed <= fixed;
		row_want <= want;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// handshakes are sampled at the falling edge, ahead of the rising edge that takes them
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_reply = '{data_out, status, count};
				if (pending_replies.size() == 0) begin
					$error("result with nothing pending: data_out %h status %0d count %0d",
						data_out, status, count);
					fail_count++;
				end else begin
					want_reply = pending_replies.pop_front();
					if (got_reply.word !== want_reply.word) begin
						$error("data_out: expected %h, got %h", want_reply.word, got_reply.word);
						fail_count++;
					end
					if (got_reply.code !== want_reply.code) begin
						$error("status: expected %0d, got %0d", want_reply.code, got_reply.code);
						fail_count++;
					end
					if (got_reply.length !== want_reply.length) begin
						$error("count: expected %0d, got %0d", want_reply.length,
							got_reply.length);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				want_reply = step_deque(mode, data_in);
				pending_replies.push_back(row_fixed ? row_want : want_reply);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		out_ready <= 1'b0;
		rx_left = 0;
		rx_tick = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_style = rx_style_e'($urandom_range(0, 3));
				rx_left = $urandom_range(10, 80);
			end
			rx_left--;
			rx_tick++;
			case (rx_style)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (rx_tick % 3 != 0);
			endcase
		end
	end

	initial begin
		op_mix_e mix;
		int mix_left;
		logic [2:0] op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_PUSH_FRONT;
		data_in <= '0;
		row_fixed <= 1'b0;
		row_want <= '0;
		burst_left = 0;

		// every pop and peek on an empty deque, unused modes, pushes and peeks at both ends, both word extremes
		directed_rows.push_back('{MODE_POP_FRONT, '1, 1'b1, '{'0, STATUS_EMPTY, 5'd0}});
		directed_rows.push_back('{MODE_POP_BACK, '0, 1'b1, '{'0, STATUS_EMPTY, 5'd0}});
		directed_rows.push_back('{MODE_PEEK_FRONT, '1, 1'b1, '{'0, STATUS_EMPTY, 5'd0}});
		directed_rows.push_back('{MODE_PEEK_BACK, '0, 1'b1, '{'0, STATUS_EMPTY, 5'd0}});
		directed_rows.push_back('{MODE_UNUSED_LO, '1, 1'b1, '{'0, STATUS_OK, 5'd0}});
		directed_rows.push_back('{MODE_UNUSED_HI, '1, 1'b1, '{'0, STATUS_OK, 5'd0}});
		directed_rows.push_back('{MODE_PUSH_BACK, '1, 1'b1, '{'0, STATUS_OK, 5'd1}});
		directed_rows.push_back('{MODE_PUSH_FRONT, '0, 1'b1, '{'0, STATUS_OK, 5'd2}});
		directed_rows.push_back('{MODE_PEEK_FRONT, '1, 1'b1, '{'0, STATUS_OK, 5'd2}});
		directed_rows.push_back('{MODE_PEEK_BACK, '0, 1'b1, '{'1, STATUS_OK, 5'd2}});
		for (int i = 0; i < DEPTH_DEF - 2; i++)
			directed_rows.push_back('{(i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
				PORT_WORD_W'($urandom), 1'b0, '0});
		// full deque drops pushes at either end
		directed_rows.push_back('{MODE_PUSH_BACK, '1, 1'b1,
			'{'0, STATUS_FULL, PORT_COUNT_W'(DEPTH_DEF)}});
		directed_rows.push_back('{MODE_PUSH_FRONT, '1, 1'b1,
			'{'0, STATUS_FULL, PORT_COUNT_W'(DEPTH_DEF)}});
		directed_rows.push_back('{MODE_POP_FRONT, '0, 1'b0, '0});
		directed_rows.push_back('{MODE_POP_BACK, '0, 1'b0, '0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].word, directed_rows[i].fixed,
				directed_rows[i].want);

		mix = MIX_FILL;
		mix_left = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (mix_left == 0) begin
				mix = op_mix_e'($urandom_range(0, 2));
				mix_left = $urandom_range(24, 40);
			end
			mix_left--;
			op = pick_mode(mix);
			send_op(op, pick_word(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
dv/double_ended_queue_test.sv
